FILE: rtl/core/tcpst_pkg.sv
// Shared types, constants and helpers of the TCP session table.
package tcpst_pkg;

   localparam int SLOT_COUNT    = 64;
   localparam int SLOT_BITS     = $clog2(SLOT_COUNT);
   localparam int SLOT_ID_WIDTH = 6;
   localparam int LENGTH_WIDTH  = 11;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_BITS    = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] PROTO_TCP        = 8'd6;
   localparam logic [7:0] ETH_HEADER_BYTES = 8'd14;

   typedef enum logic [1:0] {
      OP_PASS,
      OP_OPEN,
      OP_CLOSE,
      OP_LOOK
   } op_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_DRAIN,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic [31:0] src_address;
      logic [31:0] dst_address;
      logic [15:0] src_port;
      logic [15:0] dst_port;
   } tuple_type;

   typedef struct packed {
      op_type                  op;
      tuple_type               tuple;
      logic [LENGTH_WIDTH-1:0] payload_length;
   } job_type;

   typedef struct packed {
      logic                     is_tcp;
      logic [SLOT_ID_WIDTH-1:0] slot_id;
      logic                     hit;
      logic                     created;
      logic                     table_full;
      logic                     released;
      logic [LENGTH_WIDTH-1:0]  payload_length;
   } rsp_type;

   // low six bits of a slot number, zero-extended for small tables
   function automatic logic [SLOT_ID_WIDTH-1:0] slot_id_of(input logic [SLOT_BITS-1:0] idx);
      logic [SLOT_BITS+SLOT_ID_WIDTH-1:0] wide;
      wide = {{SLOT_ID_WIDTH{1'b0}}, idx};
      return wide[SLOT_ID_WIDTH-1:0];
   endfunction

endpackage

FILE: rtl/core/tcpst_if.sv
// Request and response channel interfaces of the TCP session table.
interface tcpst_req_if;
   import tcpst_pkg::*;
   logic        valid;
   logic        ready;
   logic [7:0]  protocol;
   logic [3:0]  ip_header_words;
   logic [3:0]  tcp_header_words;
   logic [LENGTH_WIDTH-1:0] frame_length;
   logic [31:0] src_address;
   logic [31:0] dst_address;
   logic [15:0] src_port;
   logic [15:0] dst_port;
   logic        syn_flag;
   logic        fin_flag;

   modport source (output valid, protocol, ip_header_words, tcp_header_words, frame_length,
                   src_address, dst_address, src_port, dst_port, syn_flag, fin_flag,
                   input ready);
   modport sink (input valid, protocol, ip_header_words, tcp_header_words, frame_length,
                 src_address, dst_address, src_port, dst_port, syn_flag, fin_flag,
                 output ready);
endinterface

interface tcpst_rsp_if;
   import tcpst_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     is_tcp;
   logic [SLOT_ID_WIDTH-1:0] slot_id;
   logic                     hit;
   logic                     created;
   logic                     table_full;
   logic                     released;
   logic [LENGTH_WIDTH-1:0]  payload_length;

   modport source (output valid, is_tcp, slot_id, hit, created, table_full, released,
                   payload_length, input ready);
   modport sink (input valid, is_tcp, slot_id, hit, created, table_full, released,
                 payload_length, output ready);
endinterface

FILE: rtl/core/tcpst_front.sv
// Front end: takes requests, classifies them and computes the payload length.
module tcpst_front (
   tcpst_req_if.sink          req_bus,
   input  logic               queue_full,
   output logic               push,
   output tcpst_pkg::job_type push_job
);
   import tcpst_pkg::*;

   logic [7:0]              hdr_bytes;
   logic [LENGTH_WIDTH-1:0] hdr_ext;

   assign req_bus.ready = !queue_full;
   assign push          = req_bus.valid && !queue_full;

   always_comb begin
      hdr_bytes = ETH_HEADER_BYTES + {2'b00, req_bus.ip_header_words, 2'b00}
                + {2'b00, req_bus.tcp_header_words, 2'b00};
      hdr_ext   = {{(LENGTH_WIDTH-8){1'b0}}, hdr_bytes};

      push_job.tuple.src_address = req_bus.src_address;
      push_job.tuple.dst_address = req_bus.dst_address;
      push_job.tuple.src_port    = req_bus.src_port;
      push_job.tuple.dst_port    = req_bus.dst_port;
      push_job.payload_length    = '0;

      if (req_bus.protocol != PROTO_TCP) begin
         push_job.op = OP_PASS;
      end else begin
         if (req_bus.frame_length > hdr_ext) begin
            push_job.payload_length = req_bus.frame_length - hdr_ext;
         end
         if (req_bus.syn_flag) begin
            push_job.op = OP_OPEN;
         end else if (req_bus.fin_flag) begin
            push_job.op = OP_CLOSE;
         end else begin
            push_job.op = OP_LOOK;
         end
      end
   end

endmodule

FILE: rtl/core/tcpst_queue.sv
// Short job queue between the front end and the table engine.
module tcpst_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tcpst_pkg::job_type push_job,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output tcpst_pkg::job_type head_job
);
   import tcpst_pkg::*;

   job_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_BITS:0]     count_ff, count_in;

   assign full     = count_ff == (QUEUE_BITS+1)'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_BITS+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: rtl/core/tcpst_back.sv
// Table engine: scans the slots, allocates or frees one, registers the response.
module tcpst_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               empty,
   input  tcpst_pkg::job_type head_job,
   output logic               pop,
   tcpst_rsp_if.source        rsp_bus
);
   import tcpst_pkg::*;

   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOT_COUNT - 1);

   tuple_type            tuple_mem [SLOT_COUNT];
   tuple_type            rd_tuple_ff;

   back_state_type       state_ff, state_in;
   logic [SLOT_BITS-1:0] scan_ff, scan_in;
   logic                 cmp_valid_ff;
   logic [SLOT_BITS-1:0] cmp_idx_ff;
   logic                 found_match_ff, found_match_in;
   logic [SLOT_BITS-1:0] match_ff, match_in;
   logic                 found_free_ff, found_free_in;
   logic [SLOT_BITS-1:0] free_ff, free_in;
   logic [SLOT_COUNT-1:0] in_use_ff, in_use_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 issue;
   logic                 clear_finds;
   logic                 done_fire;
   logic                 out_free;
   logic                 hit_now;
   logic                 free_now;
   logic                 pick_free;
   logic                 wr_en;
   logic                 clr_en;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign hit_now  = cmp_valid_ff && in_use_ff[cmp_idx_ff] && (rd_tuple_ff == head_job.tuple);
   assign free_now = cmp_valid_ff && !in_use_ff[cmp_idx_ff];
   assign pop      = done_fire;

   always_comb begin
      state_in    = state_ff;
      scan_in     = scan_ff;
      issue       = 1'b0;
      clear_finds = 1'b0;
      done_fire   = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!empty) begin
               clear_finds = 1'b1;
               scan_in     = '0;
               state_in    = (head_job.op == OP_PASS) ? BK_DONE : BK_SCAN;
            end
         end
         BK_SCAN: begin
            issue   = 1'b1;
            scan_in = scan_ff + SLOT_BITS'(1);
            if (scan_ff == LAST_SLOT) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            state_in = BK_DONE;
         end
         BK_DONE: begin
            if (out_free) begin
               done_fire = 1'b1;
               state_in  = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // lowest match and lowest free slot, first hit wins
   always_comb begin
      found_match_in = found_match_ff;
      match_in       = match_ff;
      found_free_in  = found_free_ff;
      free_in        = free_ff;
      if (clear_finds) begin
         found_match_in = 1'b0;
         found_free_in  = 1'b0;
      end else begin
         if (hit_now && !found_match_ff) begin
            found_match_in = 1'b1;
            match_in       = cmp_idx_ff;
         end
         if (free_now && !found_free_ff) begin
            found_free_in = 1'b1;
            free_in       = cmp_idx_ff;
         end
      end
   end

   always_comb begin
      pick_free = found_free_ff && (!found_match_ff || (free_ff < match_ff));
      wr_en     = done_fire && (head_job.op == OP_OPEN) && found_free_ff;
      clr_en    = done_fire && (head_job.op == OP_CLOSE) && found_match_ff;

      in_use_in = in_use_ff;
      if (wr_en) begin
         in_use_in[free_ff] = 1'b1;
      end
      if (clr_en) begin
         in_use_in[match_ff] = 1'b0;
      end

      rsp_in                = '0;
      rsp_in.payload_length = head_job.payload_length;
      case (head_job.op)
         OP_PASS: begin
            rsp_in.payload_length = '0;
         end
         OP_OPEN: begin
            rsp_in.is_tcp     = 1'b1;
            rsp_in.created    = found_free_ff;
            rsp_in.table_full = !found_free_ff;
            rsp_in.hit        = found_free_ff || found_match_ff;
            if (pick_free) begin
               rsp_in.slot_id = slot_id_of(free_ff);
            end else if (found_match_ff) begin
               rsp_in.slot_id = slot_id_of(match_ff);
            end
         end
         OP_CLOSE: begin
            rsp_in.is_tcp   = 1'b1;
            rsp_in.hit      = found_match_ff;
            rsp_in.released = found_match_ff;
            if (found_match_ff) begin
               rsp_in.slot_id = slot_id_of(match_ff);
            end
         end
         default: begin
            rsp_in.is_tcp = 1'b1;
            rsp_in.hit    = found_match_ff;
            if (found_match_ff) begin
               rsp_in.slot_id = slot_id_of(match_ff);
            end
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (done_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= BK_IDLE;
         cmp_valid_ff   <= 1'b0;
         found_match_ff <= 1'b0;
         found_free_ff  <= 1'b0;
         in_use_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cmp_valid_ff   <= issue;
         found_match_ff <= found_match_in;
         found_free_ff  <= found_free_in;
         in_use_ff      <= in_use_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff    <= scan_in;
      cmp_idx_ff <= scan_ff;
      match_ff   <= match_in;
      free_ff    <= free_in;
      if (done_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_tuple_ff <= tuple_mem[scan_ff];
      end
      if (wr_en) begin
         tuple_mem[free_ff] <= head_job.tuple;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.is_tcp         = rsp_ff.is_tcp;
   assign rsp_bus.slot_id        = rsp_ff.slot_id;
   assign rsp_bus.hit            = rsp_ff.hit;
   assign rsp_bus.created        = rsp_ff.created;
   assign rsp_bus.table_full     = rsp_ff.table_full;
   assign rsp_bus.released       = rsp_ff.released;
   assign rsp_bus.payload_length = rsp_ff.payload_length;

endmodule

FILE: rtl/core/tcp_session_table.sv
// TCP session table top level.
// Every TCP request scans all SLOT_COUNT slots of the tuple memory, one slot per cycle
// through its single read port, then drains the last compare before answering; a non-TCP
// request skips the scan and answers with all fields zero. A two-entry queue lets requests
// be taken while the engine scans, and the response register lets the next request start
// while a response waits to be taken.
// The slot-in-use bits are cleared by reset, so the table is usable in the cycle after.
module tcp_session_table (
   input  logic         clock,
   input  logic         reset,
   tcpst_req_if.sink    req_bus,
   tcpst_rsp_if.source  rsp_bus
);
   import tcpst_pkg::*;

   logic    push;
   logic    pop;
   logic    queue_full;
   logic    queue_empty;
   job_type push_job;
   job_type head_job;

   tcpst_front u_front (
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   tcpst_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .head_job (head_job)
   );

   tcpst_back u_back (
      .clock    (clock),
      .reset    (reset),
      .empty    (queue_empty),
      .head_job (head_job),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

endmodule
